// ----- hw/rtl/ccrc_pkg.sv -----
`default_nettype none

package ccrc_pkg;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result queue at the output
    localparam int OUT_DEPTH   = 2;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    // Configuration register indexes
    localparam int          CFG_IDX_W          = 3;
    localparam logic [2:0]  REG_WIDTH_SELECT   = 3'd0;
    localparam logic [2:0]  REG_POLYNOMIAL     = 3'd1;
    localparam logic [2:0]  REG_INITIAL_VALUE  = 3'd2;
    localparam logic [2:0]  REG_FINAL_XOR      = 3'd3;
    localparam logic [2:0]  REG_REFLECT_INPUT  = 3'd4;
    localparam logic [2:0]  REG_REFLECT_OUTPUT = 3'd5;

    // Width select codes; any other code means 32 bits
    localparam logic [1:0]  WIDTH_8  = 2'd0;
    localparam logic [1:0]  WIDTH_16 = 2'd1;
    localparam logic [1:0]  WIDTH_32 = 2'd2;

    // Reset values of the configuration registers
    localparam logic [31:0] RST_POLYNOMIAL    = 32'h04C1_1DB7;
    localparam logic [31:0] RST_INITIAL_VALUE = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_FINAL_XOR     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        is_last;
        logic [31:0] expected_check;
    } t_item;

    typedef struct packed {
        logic [31:0] crc_value;
        logic        check_match;
    } t_result;

    typedef struct packed {
        logic [1:0]  width_select;
        logic [31:0] polynomial;
        logic [31:0] initial_value;
        logic [31:0] final_xor;
        logic        reflect_input;
        logic        reflect_output;
    } t_cfg;

    // Left shift that puts the top bit of the selected width at bit 31
    function automatic logic [4:0] align_shift(input logic [1:0] sel);
        logic [4:0] sh;
        case (sel)
            WIDTH_8:  sh = 5'd24;
            WIDTH_16: sh = 5'd16;
            default:  sh = 5'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [31:0] reverse32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/configurable_crc_engine.sv -----
// Items wait in the input queue; a message's result waits in the result queue for the ports.
// One item per cycle unless a queue is full; the eight-step byte update is combinational.
// A four-entry queue parts the input from the CRC unit, a two-entry queue holds results.
// Reset (synchronous, active low): empties both queues, closes any message and loads
// the configuration registers with their defaults; no clearing pass is needed.
`default_nettype none

module configurable_crc_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_has_byte,
    input  wire logic                              i_is_last,
    input  wire logic [31:0]                       i_expected_check,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [31:0]                            o_crc_value,
    output logic                                   o_check_match,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ccrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data
);

    ccrc_pkg::t_cfg  r_cfg;
    ccrc_pkg::t_item in_item;
    ccrc_pkg::t_item q_item;
    logic            q_valid;
    logic            q_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_select   <= ccrc_pkg::WIDTH_32;
            r_cfg.polynomial     <= ccrc_pkg::RST_POLYNOMIAL;
            r_cfg.initial_value  <= ccrc_pkg::RST_INITIAL_VALUE;
            r_cfg.final_xor      <= ccrc_pkg::RST_FINAL_XOR;
            r_cfg.reflect_input  <= 1'b1;
            r_cfg.reflect_output <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ccrc_pkg::REG_WIDTH_SELECT:   r_cfg.width_select   <= i_cfg_data[1:0];
                ccrc_pkg::REG_POLYNOMIAL:     r_cfg.polynomial     <= i_cfg_data;
                ccrc_pkg::REG_INITIAL_VALUE:  r_cfg.initial_value  <= i_cfg_data;
                ccrc_pkg::REG_FINAL_XOR:      r_cfg.final_xor      <= i_cfg_data;
                ccrc_pkg::REG_REFLECT_INPUT:  r_cfg.reflect_input  <= i_cfg_data[0];
                ccrc_pkg::REG_REFLECT_OUTPUT: r_cfg.reflect_output <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Gather the input item
    always_comb begin
        in_item.data_byte      = i_data_byte;
        in_item.has_byte       = i_has_byte;
        in_item.is_last        = i_is_last;
        in_item.expected_check = i_expected_check;
    end

    ccrc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (in_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    ccrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_crc_value   (o_crc_value),
        .o_check_match (o_check_match)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ccrc_front.sv -----
`default_nettype none

module ccrc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire ccrc_pkg::t_item  i_item,
    output logic                  o_q_valid,
    output ccrc_pkg::t_item       o_q_item,
    input  wire logic             i_q_pop
);

    ccrc_pkg::t_item                    r_q [ccrc_pkg::QUEUE_DEPTH];
    logic [ccrc_pkg::QPTR_W-1:0]        r_wr, n_wr;
    logic [ccrc_pkg::QPTR_W-1:0]        r_rd, n_rd;
    logic [ccrc_pkg::QCNT_W-1:0]        r_count, n_count;
    logic                               accept;
    logic                               keep;

    // Take an item when there is room; keep only items with a byte or an end mark
    assign full   = (r_count == ccrc_pkg::QCNT_W'(ccrc_pkg::QUEUE_DEPTH));
    assign accept = push && !full;
    assign keep   = accept && (i_item.has_byte || i_item.is_last);

    // Present the oldest queued item
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rd];

    // Advance pointers and count
    always_comb begin
        n_wr    = keep    ? r_wr + 1'b1 : r_wr;
        n_rd    = i_q_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (keep && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!keep && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the item
    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_q[r_wr] <= i_item;
        end
    end

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_count_rises: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (keep && !i_q_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on a kept item");

    a_dropped_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !keep && !i_q_pop) |=> $stable(r_count) && $stable(r_wr))
        else $error("item without byte or end mark entered the queue");

endmodule

`default_nettype wire

// ----- hw/rtl/ccrc_back.sv -----
`default_nettype none

module ccrc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ccrc_pkg::t_cfg   i_cfg,
    input  wire logic             i_q_valid,
    input  wire ccrc_pkg::t_item  i_q_item,
    output logic                  o_q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output logic [31:0]           o_crc_value,
    output logic                  o_check_match
);

    logic [31:0]                   r_crc;
    logic                          r_in_msg;
    ccrc_pkg::t_result             r_out [ccrc_pkg::OUT_DEPTH];
    logic [ccrc_pkg::OPTR_W-1:0]   r_owr, r_ord;
    logic [ccrc_pkg::OCNT_W-1:0]   r_ocount, n_ocount;

    logic        pop_acc;
    logic        out_space;
    logic        take;
    logic        emit;
    logic [4:0]  sh;
    logic [31:0] mask;
    logic [31:0] crc_al;
    logic [31:0] poly_al;
    logic [31:0] step_al;
    logic [31:0] next_al;
    logic [31:0] crc_new;
    logic [31:0] res_pre;
    logic [31:0] res_val;
    logic [7:0]  byte_in;
    ccrc_pkg::t_result result;

    // Handshakes on both sides
    assign pop_acc   = pop && !empty;
    assign out_space = (r_ocount != ccrc_pkg::OCNT_W'(ccrc_pkg::OUT_DEPTH)) || pop_acc;
    assign take      = i_q_valid && (!i_q_item.is_last || out_space);
    assign emit      = take && i_q_item.is_last;
    assign o_q_pop   = take;

    // Byte step: work with the register aligned to bit 31, eight LFSR shifts
    always_comb begin
        sh      = ccrc_pkg::align_shift(i_cfg.width_select);
        mask    = 32'hFFFF_FFFF >> sh;
        crc_al  = (r_in_msg ? r_crc : i_cfg.initial_value) << sh;
        poly_al = i_cfg.polynomial << sh;
        byte_in = i_cfg.reflect_input ? ccrc_pkg::reverse8(i_q_item.data_byte)
                                      : i_q_item.data_byte;
        step_al = crc_al ^ {byte_in, 24'd0};
        for (int j = 0; j < 8; j++) begin
            step_al = {step_al[30:0], 1'b0} ^ (step_al[31] ? poly_al : 32'd0);
        end
        next_al = i_q_item.has_byte ? step_al : crc_al;
        crc_new = next_al >> sh;
    end

    // Finish: reflect over the width, apply the XOR, compare
    always_comb begin
        res_pre = i_cfg.reflect_output ? ccrc_pkg::reverse32(next_al) : crc_new;
        res_val = (res_pre ^ i_cfg.final_xor) & mask;
        result.crc_value   = res_val;
        result.check_match = (res_val == (i_q_item.expected_check & mask));
    end

    // Hold the running register and the message flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else if (take) begin
            r_in_msg <= !i_q_item.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_crc <= crc_new;
        end
    end

    // Result queue
    always_comb begin
        n_ocount = r_ocount;
        if (emit && !pop_acc) begin
            n_ocount = r_ocount + 1'b1;
        end else if (!emit && pop_acc) begin
            n_ocount = r_ocount - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr    <= '0;
            r_ord    <= '0;
            r_ocount <= '0;
        end else begin
            r_ocount <= n_ocount;
            if (emit) begin
                r_owr <= r_owr + 1'b1;
            end
            if (pop_acc) begin
                r_ord <= r_ord + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out[r_owr] <= result;
        end
    end

    assign empty         = (r_ocount == '0);
    assign o_crc_value   = r_out[r_ord].crc_value;
    assign o_check_match = r_out[r_ord].check_match;

    a_ocount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocount <= ccrc_pkg::OCNT_W'(ccrc_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    a_msg_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !r_in_msg)
        else $error("message still open after its last item");

    a_result_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !pop_acc) |=> (r_ocount == $past(r_ocount) + 1'b1))
        else $error("result not queued");

endmodule

`default_nettype wire

// ----- sim/crc_result_checker.sv -----
`timescale 1ns / 1ps

// Watches the item, result and register channels of the CRC engine, predicts each
// result from its own copy of the registers and compares it with what comes out.
module crc_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_has_byte,
    input  logic                           i_is_last,
    input  logic [31:0]                    i_expected_check,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [31:0]                    i_crc_value,
    input  logic                           i_check_match,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ccrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    ccrc_pkg::t_cfg    crc_cfg;
    logic [31:0]       crc_acc;
    logic              msg_open;
    ccrc_pkg::t_result crc_due[$];
    int                errs = 0;

    function automatic int unsigned crc_len(input logic [1:0] sel);
        case (sel)
            ccrc_pkg::WIDTH_8:  return 8;
            ccrc_pkg::WIDTH_16: return 16;
            default:            return 32;
        endcase
    endfunction

    function automatic logic [31:0] len_mask(input int unsigned n);
        return (n >= 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
    endfunction

    // Reverse the low n bits of v
    function automatic logic [31:0] mirror(input logic [31:0] v, input int unsigned n);
        logic [31:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            r[i] = v[n - 1 - i];
        end
        return r;
    endfunction

    // Fold one byte into the register, MSB first, eight shift steps
    function automatic logic [31:0] fold_byte(input logic [31:0] acc, input logic [7:0] b,
                                              input int unsigned n, input logic [31:0] m,
                                              input logic [31:0] poly, input logic refl);
        logic [31:0] c;
        logic [31:0] p;
        logic [7:0]  d;
        c = acc & m;
        p = poly & m;
        d = refl ? 8'(mirror({24'b0, b}, 8)) : b;
        c = c ^ ({24'b0, d} << (n - 8));
        for (int j = 0; j < 8; j++) begin
            if (c[n - 1]) c = ((c << 1) ^ p) & m;
            else c = (c << 1) & m;
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        ccrc_pkg::t_result want;
        int unsigned       n;
        logic [31:0]       m;
        logic [31:0]       res;
        if (!i_rst_n) begin
            crc_cfg.width_select   = ccrc_pkg::WIDTH_32;
            crc_cfg.polynomial     = ccrc_pkg::RST_POLYNOMIAL;
            crc_cfg.initial_value  = ccrc_pkg::RST_INITIAL_VALUE;
            crc_cfg.final_xor      = ccrc_pkg::RST_FINAL_XOR;
            crc_cfg.reflect_input  = 1'b1;
            crc_cfg.reflect_output = 1'b1;
            crc_acc  = ccrc_pkg::RST_INITIAL_VALUE;
            msg_open = 1'b0;
            crc_due.delete();
        end else begin
            // Compare a taken result with the oldest prediction
            if (i_pop && !i_empty) begin
                if (crc_due.size() == 0) begin
                    errs++;
                    $display("%0t ERROR: result with no prediction waiting, %s %h %s %b",
                             $time, "got crc_value", i_crc_value, "check_match",
                             i_check_match);
                end else begin
                    want = crc_due.pop_front();
                    if (i_crc_value !== want.crc_value) begin
                        errs++;
                        $display("%0t ERROR: crc_value expected %h, got %h",
                                 $time, want.crc_value, i_crc_value);
                    end
                    if (i_check_match !== want.check_match) begin
                        errs++;
                        $display("%0t ERROR: check_match expected %b, got %b",
                                 $time, want.check_match, i_check_match);
                    end
                end
            end

            // Advance the predicted register on each item; drop byte-less items
            // that end nothing
            if (i_push && !i_full && (i_has_byte || i_is_last)) begin
                n = crc_len(crc_cfg.width_select);
                m = len_mask(n);
                if (!msg_open) begin
                    crc_acc  = crc_cfg.initial_value & m;
                    msg_open = 1'b1;
                end
                if (i_has_byte) begin
                    crc_acc = fold_byte(crc_acc, i_data_byte, n, m, crc_cfg.polynomial,
                                        crc_cfg.reflect_input);
                end
                if (i_is_last) begin
                    res = crc_acc & m;
                    if (crc_cfg.reflect_output) res = mirror(res, n);
                    res = (res ^ crc_cfg.final_xor) & m;
                    want.crc_value   = res;
                    want.check_match = (res == (i_expected_check & m));
                    crc_due.push_back(want);
                    crc_acc  = crc_cfg.initial_value & m;
                    msg_open = 1'b0;
                end
            end

            // Track register writes; unknown indexes are ignored
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ccrc_pkg::REG_WIDTH_SELECT:   crc_cfg.width_select   = i_cfg_data[1:0];
                    ccrc_pkg::REG_POLYNOMIAL:     crc_cfg.polynomial     = i_cfg_data;
                    ccrc_pkg::REG_INITIAL_VALUE:  crc_cfg.initial_value  = i_cfg_data;
                    ccrc_pkg::REG_FINAL_XOR:      crc_cfg.final_xor      = i_cfg_data;
                    ccrc_pkg::REG_REFLECT_INPUT:  crc_cfg.reflect_input  = i_cfg_data[0];
                    ccrc_pkg::REG_REFLECT_OUTPUT: crc_cfg.reflect_output = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= errs;
        o_pending    <= crc_due.size();
    end

endmodule

// ----- sim/tb_configurable_crc_engine.sv -----
`timescale 1ns / 1ps

module tb_configurable_crc_engine;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 650;

    // Indexes past the register list
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    // Configuration kinds for a phase
    localparam int CFG_RANDOM   = 0;
    localparam int CFG_ALL_ZERO = 1;
    localparam int CFG_ALL_ONES = 2;

    logic                           i_clk            = 1'b0;
    logic                           i_rst_n          = 1'b0;
    logic                           push             = 1'b0;
    logic [7:0]                     i_data_byte      = 8'h00;
    logic                           i_has_byte       = 1'b0;
    logic                           i_is_last        = 1'b0;
    logic [31:0]                    i_expected_check = 32'h0;
    logic                           pop              = 1'b0;
    logic                           i_cfg_valid      = 1'b0;
    logic [ccrc_pkg::CFG_IDX_W-1:0] i_cfg_index      = '0;
    logic [31:0]                    i_cfg_data       = 32'h0;

    logic        full;
    logic        empty;
    logic [31:0] o_crc_value;
    logic        o_check_match;
    logic        o_cfg_ready;

    int          fail_count;
    int          pending;
    int          cycle_count   = 0;
    int          sent_items    = 0;
    bit          steady        = 1'b0;
    bit          hold_req      = 1'b0;
    bit          rx_holding    = 1'b0;
    logic [31:0] last_seen_crc = 32'h0;
    logic [1:0]  width_code    = ccrc_pkg::WIDTH_32;
    logic [7:0]  prev_msg[$];

    configurable_crc_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_is_last        (i_is_last),
        .i_expected_check (i_expected_check),
        .empty            (empty),
        .pop              (pop),
        .o_crc_value      (o_crc_value),
        .o_check_match    (o_check_match),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    crc_result_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_is_last        (i_is_last),
        .i_expected_check (i_expected_check),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_crc_value      (o_crc_value),
        .i_check_match    (o_check_match),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #5 i_clk = ~i_clk;

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Take results with random stalls unless steady; hold off for a long stretch on request
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                rx_holding = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req   = 1'b0;
                rx_holding = 1'b0;
            end
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty && !hold_req) @(posedge i_clk);
            if (!empty) last_seen_crc = o_crc_value;
        end
    end

    // Offer one item, after a random gap unless steady, and hold it until taken
    task automatic send_item(input logic [7:0] d, input logic h, input logic l,
                             input logic [31:0] chk);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_data_byte      <= d;
        i_has_byte       <= h;
        i_is_last        <= l;
        i_expected_check <= chk;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (h || l) sent_items++;
    endtask

    // Stop offering and wait until every predicted result has been taken
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Valid stays high across back-to-back writes; cfg_close lowers it
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == ccrc_pkg::REG_WIDTH_SELECT) width_code = data[1:0];
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] active_mask();
        case (width_code)
            ccrc_pkg::WIDTH_8:  return 32'h0000_00FF;
            ccrc_pkg::WIDTH_16: return 32'h0000_FFFF;
            default:            return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_poly();
        case ($urandom_range(0, 9))
            0:       return 32'h04C1_1DB7;
            1:       return 32'h0000_8005;
            2:       return 32'h0000_1021;
            3:       return 32'h0000_0007;
            4:       return 32'h0000_0031;
            5:       return 32'h0000_3D65;
            default: return pick_word();
        endcase
    endfunction

    // Send a message; either the last byte or a separate byte-less item closes it
    task automatic send_message(input logic [7:0] msg[$], input bit close_on_byte,
                                input logic [31:0] chk, input bit noisy);
        int last_i;
        last_i = msg.size() - 1;
        for (int i = 0; i < msg.size(); i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                send_item(8'($urandom), 1'b0, 1'b0, $urandom);
            end
            send_item(msg[i], 1'b1, close_on_byte && (i == last_i), chk);
        end
        if (!close_on_byte || msg.size() == 0) send_item(8'($urandom), 1'b0, 1'b1, chk);
        prev_msg = msg;
    endtask

    task automatic random_message();
        logic [7:0]  body[$];
        int          len;
        logic [31:0] chk;
        case ($urandom_range(0, 9))
            0:       len = 0;
            8:       len = $urandom_range(7, 16);
            9:       len = $urandom_range(1, 3);
            default: len = $urandom_range(1, 6);
        endcase
        for (int i = 0; i < len; i++) body.push_back(8'($urandom));
        case ($urandom_range(0, 7))
            0:       chk = 32'h0;
            1:       chk = 32'hFFFF_FFFF;
            default: chk = $urandom;
        endcase
        send_message(body, $urandom_range(0, 2) != 0, chk, 1'b1);
    endtask

    // Write a phase's registers; random phases leave some registers as they were
    task automatic phase_config(input int kind);
        logic [31:0] w;
        case (kind)
            CFG_ALL_ZERO: begin
                cfg_write(ccrc_pkg::REG_WIDTH_SELECT, 32'h0);
                cfg_write(ccrc_pkg::REG_POLYNOMIAL, 32'h0);
                cfg_write(ccrc_pkg::REG_INITIAL_VALUE, 32'h0);
                cfg_write(ccrc_pkg::REG_FINAL_XOR, 32'h0);
                cfg_write(ccrc_pkg::REG_REFLECT_INPUT, 32'h0);
                cfg_write(ccrc_pkg::REG_REFLECT_OUTPUT, 32'h0);
            end
            CFG_ALL_ONES: begin
                cfg_write(ccrc_pkg::REG_WIDTH_SELECT, 32'hFFFF_FFFF);
                cfg_write(ccrc_pkg::REG_POLYNOMIAL, 32'hFFFF_FFFF);
                cfg_write(ccrc_pkg::REG_INITIAL_VALUE, 32'hFFFF_FFFF);
                cfg_write(ccrc_pkg::REG_FINAL_XOR, 32'hFFFF_FFFF);
                cfg_write(ccrc_pkg::REG_REFLECT_INPUT, 32'hFFFF_FFFF);
                cfg_write(ccrc_pkg::REG_REFLECT_OUTPUT, 32'hFFFF_FFFF);
            end
            default: begin
                w = $urandom;
                w[1:0] = 2'($urandom_range(0, 3));
                cfg_write(ccrc_pkg::REG_WIDTH_SELECT, w);
                if ($urandom_range(0, 3) != 0) begin
                    cfg_write(ccrc_pkg::REG_POLYNOMIAL, pick_poly());
                end
                if ($urandom_range(0, 3) != 0) begin
                    cfg_write(ccrc_pkg::REG_INITIAL_VALUE, pick_word());
                end
                if ($urandom_range(0, 3) != 0) begin
                    cfg_write(ccrc_pkg::REG_FINAL_XOR, pick_word());
                end
                if ($urandom_range(0, 3) != 0) begin
                    cfg_write(ccrc_pkg::REG_REFLECT_INPUT, $urandom);
                end
                if ($urandom_range(0, 3) != 0) begin
                    cfg_write(ccrc_pkg::REG_REFLECT_OUTPUT, $urandom);
                end
                if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE_A, $urandom);
                if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE_B, $urandom);
            end
        endcase
        cfg_close();
    endtask

    initial begin : stimulus
        logic [7:0]  digits[$];
        logic [31:0] chk;
        int          phase;
        int          goal;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 9; i++) digits.push_back(8'(32'h31 + i));

        // Catalogue check value of CRC-32 under the reset registers
        send_message(digits, 1'b1, 32'hCBF4_3926, 1'b0);
        // Empty message, an ignored item, then single bytes at both extremes
        send_item(8'hA5, 1'b0, 1'b1, 32'h0);
        send_item(8'hFF, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(8'h00, 1'b1, 1'b1, 32'h0);
        send_item(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // Message closed by a byte-less item, with an ignored item inside it
        send_item(8'h80, 1'b1, 1'b0, 32'h0);
        send_item(8'h01, 1'b0, 1'b0, 32'h0);
        send_item(8'h7F, 1'b0, 1'b1, 32'hFFFF_FFFF);
        drain();

        // Unreflected CRC-8; check bits above the width must not matter
        cfg_write(ccrc_pkg::REG_WIDTH_SELECT, 32'(ccrc_pkg::WIDTH_8));
        cfg_write(ccrc_pkg::REG_POLYNOMIAL, 32'h0000_0007);
        cfg_write(ccrc_pkg::REG_INITIAL_VALUE, 32'h0);
        cfg_write(ccrc_pkg::REG_FINAL_XOR, 32'h0);
        cfg_write(ccrc_pkg::REG_REFLECT_INPUT, 32'h0);
        cfg_write(ccrc_pkg::REG_REFLECT_OUTPUT, 32'h0);
        cfg_close();
        send_message(digits, 1'b1, 32'hFFFF_FFF4, 1'b0);
        drain();

        goal = sent_items + RANDOM_ITEMS;

        // Fill the block while the receiver holds off
        phase_config(CFG_RANDOM);
        hold_req = 1'b1;
        wait (rx_holding);
        steady = 1'b1;
        repeat (40) send_item(8'($urandom), 1'b1, 1'b1, $urandom);
        steady = 1'b0;
        drain();

        // Zero, ones, then random phases, each closed by a replay using the last result as check
        phase = 0;
        while (sent_items < goal) begin
            if (phase == 0) phase_config(CFG_ALL_ZERO);
            else if (phase == 1) phase_config(CFG_ALL_ONES);
            else phase_config(CFG_RANDOM);
            steady = ($urandom_range(0, 3) == 0);
            repeat (8) random_message();
            steady = 1'b0;
            drain();
            chk = last_seen_crc | ($urandom & ~active_mask());
            if ($urandom_range(0, 3) == 0) chk = chk ^ 32'h1;
            send_message(prev_msg, 1'($urandom_range(0, 1)), chk, 1'b0);
            drain();
            phase++;
        end

        drain();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
